FILE: sv/kmeans_nearest_centroid_pass_macros.svh
// Assertion macros used by the checker file.
`ifndef KMEANS_NEAREST_CENTROID_PASS_MACROS_SVH
`define KMEANS_NEAREST_CENTROID_PASS_MACROS_SVH
// Implication checked on every rising clock edge, ignored while reset is low.
`define KNC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define KNC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/knc_pkg.sv
// ----------------------------------------------------------------------------
// knc_pkg
// Types and constants shared by the nearest-centroid pass block.
// ----------------------------------------------------------------------------
`default_nettype none
package knc_pkg;
  localparam int unsigned CompW  = 16;
  localparam int unsigned CntW   = 23;
  localparam int unsigned SumW   = 38;
  localparam int unsigned DistW  = 34;
  localparam int unsigned LabelW = 4;
  localparam int unsigned NDimMax = 4;

  // saturation point of the member and moved counters
  localparam logic [CntW-1:0] MaxPoints = 23'd4194304;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModePoint = 2'd1;
  localparam logic [1:0] ModeEnd   = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam logic [1:0] RegClusters  = 2'd0;
  localparam logic [1:0] RegDims      = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic [3:0]              cluster_in;
    logic [3:0]              prev_label;
    logic [3:0][CompW-1:0]   comp;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic [3:0]              cluster;
    logic                    moved;
    logic [3:0][CompW-1:0]   cen;
    logic [CntW-1:0]         member_count;
    logic [CntW-1:0]         change_count;
    logic                    converged;
    logic                    last;
  } out_item_t;

  // squared distance of one component pair
  function automatic logic [DistW-1:0] sq_diff(input logic [CompW-1:0] a,
                                               input logic [CompW-1:0] b);
    logic [CompW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return DistW'(d) * DistW'(d);
  endfunction
endpackage
`default_nettype wire

FILE: sv/knc_if.sv
// ----------------------------------------------------------------------------
// knc_in_if / knc_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface knc_in_if;
  logic valid;
  logic ready;
  knc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface knc_out_if;
  logic valid;
  logic ready;
  knc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/kmeans_nearest_centroid_pass.sv
// ----------------------------------------------------------------------------
// kmeans_nearest_centroid_pass
// Nearest-centroid pass of Lloyd k-means.
// Channels: in_if (sink) takes items with mode load/point/end; out_if
// (source) gives results. A config write port sets the cluster count, the
// dimension count and the convergence threshold; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Load: no result. Point: the item walks a chain of N = min(MAX_CLUSTERS,
// 16) cells, one cell per cycle; the label result is registered as the
// wave leaves the last cell. End: per active cluster one division per
// active component (start, 38 quotient bits, hand-off) and one emit step;
// when converged the divisions are skipped and each centroid leaves as soon
// as the result register is free. One item is in work at a time.
// Reset clears centroids, sums, counters and registers to their defaults.
// A stalled receiver holds the result register and the block takes no new
// item until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module kmeans_nearest_centroid_pass #(
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned MAX_DIMS     = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  knc_in_if.sink      in_if,
  knc_out_if.source   out_if,
  input  wire         cfg_we_i,
  input  wire [1:0]   cfg_idx_i,
  input  wire [13:0]  cfg_data_i
);
  import knc_pkg::*;

  localparam int unsigned NCell = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;
  localparam logic [4:0] KCap = 5'(NCell);
  localparam logic [2:0] DCap = 3'(MAX_DIMS);
  localparam logic [22:0] PMax = MaxPoints;

  typedef enum logic [2:0] {
    StIdle, StWalk, StOut, StDivStart, StDivWait, StEmit
  } state_e;

  state_e state_q;
  logic [4:0]  k_cfg_q;
  logic [2:0]  d_cfg_q;
  logic [13:0] thr_q;
  logic [4:0]  keff;
  logic [2:0]  deff;

  always_comb begin
    keff = (k_cfg_q == '0) ? 5'd1 : ((k_cfg_q > KCap) ? KCap : k_cfg_q);
    deff = (d_cfg_q == '0) ? 3'd1 : ((d_cfg_q > DCap) ? DCap : d_cfg_q);
  end

  // chain wires
  logic             pv   [NCell+1];
  logic [3:0][15:0] pc   [NCell+1];
  logic [33:0]      bst  [NCell+1];
  logic [3:0]       lb   [NCell+1];
  logic [3:0][15:0] cen  [NCell];
  logic [3:0][37:0] sums [NCell];
  logic [22:0]      cnts [NCell];

  logic       add, load, upd, clr;
  logic [3:0] add_lbl, upd_idx;
  logic [3:0][15:0] upd_val_q;
  logic [3:0] prev_q, n_q;
  logic [1:0] dim_q;
  logic [22:0] moved_q;
  logic        conv_q;
  logic        div_start, div_done;
  logic [15:0] div_quo;
  logic        out_v_q;
  out_item_t   out_q;
  logic        accept;

  assign in_if.ready = (state_q == StIdle);
  assign accept = in_if.valid && in_if.ready;

  assign pv[0]  = accept && in_if.data.mode == ModePoint;
  assign pc[0]  = in_if.data.comp;
  assign bst[0] = '0;
  assign lb[0]  = '0;
  assign load   = accept && in_if.data.mode == ModeLoad &&
                  32'(in_if.data.cluster_in) < MAX_CLUSTERS;
  assign add     = pv[NCell];
  assign add_lbl = lb[NCell];

  // cells at or above the cluster count pass the wave on without taking part in the comparison
  for (genvar g = 0; g < NCell; g++) begin : g_cell
    logic act;
    assign act = 5'(g) < keff;
    knc_cell #(.Idx(g)) u_cell (
      .clk_i, .rst_ni,
      .pv_i(pv[g]), .pcomp_i(pc[g]), .dims_i(deff), .act_i(act),
      .first_i(g == 0), .best_i(bst[g]), .lbl_i(lb[g]),
      .pv_o(pv[g+1]), .pcomp_o(pc[g+1]), .best_o(bst[g+1]), .lbl_o(lb[g+1]),
      .add_i(add), .add_lbl_i(add_lbl),
      .add_comp_i(load ? in_if.data.comp : pc[NCell]),
      .load_i(load), .load_idx_i(in_if.data.cluster_in),
      .upd_i(upd), .upd_val_i(upd_val_q), .upd_idx_i(upd_idx), .clr_i(clr),
      .cen_o(cen[g]), .sum_o(sums[g]), .cnt_o(cnts[g])
    );
  end

  logic [3:0][15:0] cen_sel;
  logic [37:0] sum_sel;
  logic [22:0] cnt_sel;
  assign cen_sel = cen[n_q];
  assign sum_sel = sums[n_q][dim_q];
  assign cnt_sel = cnts[n_q];

  knc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sum_sel), .den_i(cnt_sel),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign div_start = (state_q == StDivStart);
  assign upd       = (state_q == StEmit) && !conv_q && !out_v_q;
  assign upd_idx   = n_q;
  assign clr       = (state_q == StEmit) && !out_v_q && (5'(n_q) + 5'd1 == keff);

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      k_cfg_q   <= 5'd16;
      d_cfg_q   <= 3'd3;
      thr_q     <= '0;
      out_v_q   <= 1'b0;
      out_q     <= '0;
      moved_q   <= '0;
      n_q       <= '0;
      dim_q     <= '0;
      conv_q    <= 1'b0;
      prev_q    <= '0;
      upd_val_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegClusters:  k_cfg_q <= cfg_data_i[4:0];
          RegDims:      d_cfg_q <= cfg_data_i[2:0];
          RegThreshold: thr_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      if (clr) moved_q <= '0;
      else if (add && add_lbl != prev_q && moved_q < PMax) moved_q <= moved_q + 23'd1;
      case (state_q)
        StIdle: begin
          if (accept) begin
            prev_q <= in_if.data.prev_label;
            case (in_if.data.mode)
              ModePoint: state_q <= StWalk;
              ModeEnd: begin
                n_q    <= '0;
                dim_q  <= '0;
                conv_q <= 23'(thr_q) > moved_q;
                state_q <= (23'(thr_q) > moved_q) ? StEmit : StDivStart;
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StWalk: begin
          if (add) begin
            out_v_q <= 1'b1;
            out_q.result_kind  <= 1'b0;
            out_q.cluster      <= add_lbl;
            out_q.moved        <= add_lbl != prev_q;
            out_q.cen          <= '0;
            out_q.member_count <= '0;
            out_q.change_count <= '0;
            out_q.converged    <= 1'b0;
            out_q.last         <= 1'b0;
            state_q <= StOut;
          end
        end
        StOut: if (!out_v_q || out_if.ready) state_q <= StIdle;
        StDivStart: state_q <= StDivWait;
        StDivWait: begin
          if (div_done) begin
            upd_val_q[dim_q] <= div_quo;
            if (3'(dim_q) + 3'd1 >= deff) state_q <= StEmit;
            else begin
              dim_q   <= dim_q + 2'd1;
              state_q <= StDivStart;
            end
          end
        end
        StEmit: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1;
            out_q.result_kind  <= 1'b1;
            out_q.cluster      <= n_q;
            out_q.moved        <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              out_q.cen[i] <= (3'(i) < deff) ?
                              (conv_q ? cen_sel[i] : upd_val_q[i]) : 16'd0;
            end
            out_q.member_count <= cnt_sel;
            out_q.change_count <= moved_q;
            out_q.converged    <= conv_q;
            out_q.last         <= 5'(n_q) + 5'd1 == keff;
            if (5'(n_q) + 5'd1 == keff) state_q <= StOut;
            else begin
              n_q   <= n_q + 4'd1;
              dim_q <= '0;
              upd_val_q <= cen[n_q + 4'd1];
              state_q <= conv_q ? StEmit : StDivStart;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
      if (accept && in_if.data.mode == ModeEnd) upd_val_q <= cen[0];
    end
  end
endmodule
`default_nettype wire

FILE: sv/knc_cell.sv
// ----------------------------------------------------------------------------
// knc_cell
// One cluster cell: holds a centroid, its sums and member count. A point
// ripples along the chain one cell per cycle with the best distance so far.
// ----------------------------------------------------------------------------
`default_nettype none
module knc_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // point wave in from the left neighbor
  input  wire                      pv_i,
  input  wire [3:0][15:0]          pcomp_i,
  input  wire [2:0]                dims_i,
  input  wire                      act_i,
  input  wire                      first_i,
  input  wire [33:0]               best_i,
  input  wire [3:0]                lbl_i,
  output logic                     pv_o,
  output logic [3:0][15:0]         pcomp_o,
  output logic [33:0]              best_o,
  output logic [3:0]               lbl_o,
  // commit of a winning label
  input  wire                      add_i,
  input  wire [3:0]                add_lbl_i,
  input  wire [3:0][15:0]          add_comp_i,
  // centroid load
  input  wire                      load_i,
  input  wire [3:0]                load_idx_i,
  // end of pass: update and clear
  input  wire                      upd_i,
  input  wire [3:0][15:0]          upd_val_i,
  input  wire [3:0]                upd_idx_i,
  input  wire                      clr_i,
  output logic [3:0][15:0]         cen_o,
  output logic [3:0][37:0]         sum_o,
  output logic [22:0]              cnt_o
);
  import knc_pkg::*;

  localparam logic [3:0] MyIdx = 4'(Idx);
  localparam logic [37:0] SumMax = '1;

  logic [3:0][15:0] cen_q;
  logic [3:0][37:0] sum_q;
  logic [22:0]      cnt_q;
  logic [33:0]      dsq;

  // squared distance of incoming point to this centroid
  always_comb begin
    dsq = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < dims_i) dsq = dsq + sq_diff(pcomp_i[i], cen_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_o <= 1'b0;
    end else begin
      pv_o <= pv_i;
    end
  end

  // an inactive cell passes the best so far through unchanged
  always_ff @(posedge clk_i) begin
    pcomp_o <= pcomp_i;
    if (act_i && (first_i || dsq < best_i)) begin
      best_o <= dsq;
      lbl_o  <= MyIdx;
    end else begin
      best_o <= best_i;
      lbl_o  <= lbl_i;
    end
  end

  // stored state of this cluster
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (load_i && load_idx_i == MyIdx) cen_q <= add_comp_i;
      if (upd_i && upd_idx_i == MyIdx) cen_q <= upd_val_i;
      if (clr_i) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else if (add_i && add_lbl_i == MyIdx) begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < dims_i) begin
            sum_q[i] <= (39'(sum_q[i]) + 39'(add_comp_i[i]) > 39'(SumMax)) ?
                        SumMax : sum_q[i] + 38'(add_comp_i[i]);
          end
        end
        if (cnt_q < MaxPoints) cnt_q <= cnt_q + 23'd1;
      end
    end
  end

  assign cen_o = cen_q;
  assign sum_o = sum_q;
  assign cnt_o = cnt_q;
endmodule
`default_nettype wire

FILE: sv/knc_div.sv
// ----------------------------------------------------------------------------
// knc_div
// Restoring divider, one quotient bit per cycle: 38-bit sum by 23-bit count.
// Quotient saturates to 16 bits; zero count gives zero.
// ----------------------------------------------------------------------------
`default_nettype none
module knc_div (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  wire [37:0]   num_i,
  input  wire [22:0]   den_i,
  output logic         done_o,
  output logic [15:0]  quo_o
);
  logic [37:0] q_q;
  logic [23:0] r_q;
  logic [22:0] den_q;
  logic [5:0]  step_q;
  logic        busy_q;
  logic [23:0] trial;

  assign trial = {r_q[22:0], q_q[37]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 6'd38;
      end else if (busy_q) begin
        step_q <= step_q - 6'd1;
        if (step_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        r_q <= trial - {1'b0, den_q};
        q_q <= {q_q[36:0], 1'b1};
      end else begin
        r_q <= trial;
        q_q <= {q_q[36:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (den_q == '0) quo_o = '0;
    else if (q_q[37:16] != '0) quo_o = 16'hFFFF;
    else quo_o = q_q[15:0];
  end
endmodule
`default_nettype wire

FILE: sv/knc_checker.sv
// ----------------------------------------------------------------------------
// knc_checker
// Port-level checks of the nearest-centroid pass block.
// ----------------------------------------------------------------------------
`include "kmeans_nearest_centroid_pass_macros.svh"
`default_nettype none
module knc_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_kind_i,
  input wire out_last_i,
  input wire out_moved_i
);
  `KNC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `KNC_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid_i, !in_ready_i, "item taken while result pending")
  `KNC_ASSERT_IMP(a_last_kind, clk_i, rst_ni, out_valid_i && out_last_i, out_kind_i, "last on a point result")
  `KNC_ASSERT_IMP(a_moved_kind, clk_i, rst_ni, out_valid_i && out_moved_i, !out_kind_i, "moved on a centroid result")
endmodule

bind kmeans_nearest_centroid_pass knc_checker u_knc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_kind_i(out_if.data.result_kind), .out_last_i(out_if.data.last),
  .out_moved_i(out_if.data.moved)
);
`default_nettype wire
